FILE: hdl/positional_list_engine_defines.svh
// assertion macros shared by the positional list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ple_pkg.sv
// shared types and codes for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

    // requested action, carried in s_tuser
    typedef enum logic [2:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_DEL_HEAD = 3'd3,
        ACT_DEL_TAIL = 3'd4,
        ACT_DEL_POS  = 3'd5,
        ACT_COUNT    = 3'd6,
        ACT_READ_ALL = 3'd7
    } action_t;

    // result status, carried in m_tuser
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_FULL   = 2'd3
    } status_t;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    // controller states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } state_t;

    localparam int unsigned ValueW = 32;
    localparam int unsigned PosW   = 5;
    localparam int unsigned LenW   = 5;
    localparam int unsigned SDataW = 40;
    localparam int unsigned MDataW = 40;

endpackage

FILE: hdl/ple_cell.sv
// one storage cell of the list chain
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  logic                     aclk,
    input  cell_op_t                 op,
    input  logic [IDX_W-1:0]         pos,
    input  logic [IDX_W-1:0]         last_idx,
    input  logic [IDX_W-1:0]         cell_idx,
    input  logic signed [ValueW-1:0] ins_value,
    input  logic signed [ValueW-1:0] head_value,
    input  logic signed [ValueW-1:0] left_value,
    input  logic signed [ValueW-1:0] right_value,
    output logic signed [ValueW-1:0] data_out
);

    logic signed [ValueW-1:0] data_reg;
    logic signed [ValueW-1:0] data_next;

    // pick the new content from own value, a neighbor or the broadcast
    always_comb begin
        data_next = data_reg;
        case (op)
            CELL_HOLD: data_next = data_reg;
            CELL_INS: begin
                if (cell_idx > pos) begin
                    data_next = left_value;
                end else if (cell_idx == pos) begin
                    data_next = ins_value;
                end
            end
            CELL_DEL: begin
                if (cell_idx >= pos) begin
                    data_next = right_value;
                end
            end
            CELL_ROT: begin
                // head wraps around to the last valid cell
                if (cell_idx == last_idx) begin
                    data_next = head_value;
                end else begin
                    data_next = right_value;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

FILE: hdl/positional_list_engine.sv
// top level of the positional list engine: controller, output register and cell chain
`timescale 1ns / 1ps
`include "positional_list_engine_defines.svh"

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Each input beat carries an action in s_tuser; insert, delete and count give one
// result beat with m_tlast set. Insert and delete move all cells at or past the
// position by one place in the cycle the beat is taken. Read-all takes the beat,
// then reads one entry per cycle, unless the output register stalls, at the head
// cell while the chain rotates by one, so the list is back in order when done; an
// empty list gives a single beat with status empty. A new beat is taken only in
// idle and while the output register is free or being emptied. After reset the
// list is empty and ready at once.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SDataW-1:0] s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]        s_tuser,   // action[2:0]
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [MDataW-1:0] m_tdata,   // list_length[4:0], entry_value[36:5], zero pad
    output logic [1:0]        m_tuser,   // status[1:0]
    output logic              m_tlast
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > PosW) ? CNT_W : PosW;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              m_valid_reg, m_valid_next;

    // output payload
    status_t                  sts_reg, sts_next;
    logic [LenW-1:0]          len_reg, len_next;
    logic signed [ValueW-1:0] entry_reg, entry_next;
    logic                     last_reg, last_next;

    // decoded input beat
    action_t                  act;
    logic signed [ValueW-1:0] in_value;
    logic [PosW-1:0]          in_pos;
    logic                     acc_in;
    logic                     out_free;
    logic                     full;
    logic                     empty;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         tgt_pos;
    status_t                  op_sts;
    logic                     is_ins;
    logic                     is_del;
    logic                     emit_stream;
    logic                     stream_last;

    // chain wiring
    cell_op_t                 cell_op;
    logic [IDX_W-1:0]         cell_pos;
    logic [IDX_W-1:0]         last_idx;
    logic signed [ValueW-1:0] cell_q [CAPACITY];

    assign act      = action_t'(s_tuser);
    assign in_value = s_tdata[ValueW-1:0];
    assign in_pos   = s_tdata[ValueW +: PosW];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc_in   = s_tvalid && s_tready;

    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));

    assign emit_stream = (state_reg == ST_STREAM) && out_free;
    assign stream_last = (rd_idx_reg == last_idx);

    // target position and status of the requested action
    always_comb begin
        tgt_pos = '0;
        op_sts  = STS_OK;
        is_ins  = 1'b0;
        is_del  = 1'b0;
        unique case (act)
            ACT_INS_HEAD: begin
                is_ins  = 1'b1;
                tgt_pos = '0;
            end
            ACT_INS_TAIL: begin
                is_ins  = 1'b1;
                tgt_pos = cnt_ext;
            end
            ACT_INS_POS: begin
                is_ins  = 1'b1;
                tgt_pos = pos_ext;
            end
            ACT_DEL_HEAD: begin
                is_del  = 1'b1;
                tgt_pos = '0;
            end
            ACT_DEL_TAIL: begin
                is_del  = 1'b1;
                tgt_pos = cnt_ext - CMP_W'(1);
            end
            ACT_DEL_POS: begin
                is_del  = 1'b1;
                tgt_pos = pos_ext;
            end
            ACT_COUNT: begin
                op_sts = STS_OK;
            end
            ACT_READ_ALL: begin
                op_sts = empty ? STS_EMPTY : STS_OK;
            end
        endcase
        if (is_ins) begin
            if (full) begin
                op_sts = STS_FULL;
            end else if (tgt_pos > cnt_ext) begin
                op_sts = STS_BADPOS;
            end
        end
        if (is_del) begin
            if (empty) begin
                op_sts = STS_EMPTY;
            end else if (tgt_pos >= cnt_ext) begin
                op_sts = STS_BADPOS;
            end
        end
    end

    assign cell_pos = IDX_W'(tgt_pos);

    // chain command, count update, output beat and state sequencing
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg;
        sts_next     = sts_reg;
        len_next     = len_reg;
        entry_next   = entry_reg;
        last_next    = last_reg;
        cell_op      = CELL_HOLD;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (acc_in) begin
                    if (is_ins && op_sts == STS_OK) begin
                        cell_op  = CELL_INS;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else if (is_del && op_sts == STS_OK) begin
                        cell_op  = CELL_DEL;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    if (act == ACT_READ_ALL && !empty) begin
                        state_next  = ST_STREAM;
                        rd_idx_next = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        sts_next     = op_sts;
                        len_next     = LenW'(cnt_next);
                        entry_next   = '0;
                        last_next    = 1'b1;
                    end
                end
            end
            ST_STREAM: begin
                if (emit_stream) begin
                    cell_op      = CELL_ROT;
                    m_valid_next = 1'b1;
                    sts_next     = STS_OK;
                    len_next     = LenW'(cnt_reg);
                    entry_next   = cell_q[0];
                    last_next    = stream_last;
                    rd_idx_next  = rd_idx_reg + IDX_W'(1);
                    if (stream_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload registers
    always_ff @(posedge aclk) begin
        sts_reg   <= sts_next;
        len_reg   <= len_next;
        entry_reg <= entry_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(MDataW - ValueW - LenW)'(0), entry_reg, len_reg};
    assign m_tuser  = sts_reg;
    assign m_tlast  = last_reg;

    // row of cells, each talking to its two neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [ValueW-1:0] left_v;
        logic signed [ValueW-1:0] right_v;

        if (i == 0) begin : g_first
            assign left_v = in_value;
        end else begin : g_mid_l
            assign left_v = cell_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_v = cell_q[i];
        end else begin : g_mid_r
            assign right_v = cell_q[i+1];
        end

        ple_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk        (aclk),
            .op          (cell_op),
            .pos         (cell_pos),
            .last_idx    (last_idx),
            .cell_idx    (IDX_W'(i)),
            .ins_value   (in_value),
            .head_value  (cell_q[0]),
            .left_value  (left_v),
            .right_value (right_v),
            .data_out    (cell_q[i])
        );
    end

    // checks on count bookkeeping and read-out sequencing
    `PLE_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PLE_ASSERT_NEXT(a_ins_grows, aclk, aresetn, acc_in && is_ins && op_sts == STS_OK, cnt_reg == $past(cnt_reg) + CNT_W'(1), "insert did not grow list")
    `PLE_ASSERT_NOW(a_rd_idx_range, aclk, aresetn, state_reg == ST_STREAM, CNT_W'(rd_idx_reg) < cnt_reg, "read-out index past count")
    `PLE_ASSERT_NEXT(a_stream_end, aclk, aresetn, emit_stream && stream_last, state_reg == ST_IDLE && m_tvalid && m_tlast, "read-out did not end on last entry")

endmodule

FILE: tb/sv/positional_list_engine_test.sv
// self-checking stream testbench for the positional list engine
`timescale 1ns / 1ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int unsigned Depth      = 16;
    localparam int unsigned CycleLimit = 250000;
    localparam int unsigned DrainWait  = 40;

    // one pending input beat and the idle cycles that go before it
    typedef struct {
        action_t      act;
        logic [31:0]  value;
        logic [4:0]   pos;
        int unsigned  gap;
    } list_cmd_t;

    // one predicted result beat
    typedef struct {
        status_t      sts;
        logic [4:0]   len;
        logic [31:0]  entry;
        logic         last;
    } list_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [SDataW-1:0] s_tdata  = '0;   // value[31:0], position[36:32], zero pad
    logic [2:0]        s_tuser  = '0;   // action[2:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [MDataW-1:0] m_tdata;         // list_length[4:0], entry_value[36:5], zero pad
    logic [1:0]        m_tuser;         // status[1:0]
    logic              m_tlast;

    list_cmd_t    cmd_queue[$];
    list_result_t result_queue[$];

    // shadow copy of the list, updated when a beat is taken
    logic [31:0]  shadow_cells[Depth];
    int unsigned  shadow_len = 0;

    int unsigned  fail_count  = 0;
    int unsigned  cycle_count = 0;
    int unsigned  tx_wait     = 0;
    int unsigned  tx_calm     = 0;
    int unsigned  rx_hold     = 0;
    int unsigned  rx_calm     = 0;
    int unsigned  rx_draw;

    positional_list_engine #(
        .CAPACITY(Depth)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // queue one predicted result beat
    function automatic void push_result(status_t sts, logic [31:0] entry, logic last);
        list_result_t r;
        r.sts   = sts;
        r.len   = shadow_len[4:0];
        r.entry = entry;
        r.last  = last;
        result_queue.push_back(r);
    endfunction

    // insert into the shadow list, shifting later cells up
    function automatic status_t shadow_insert(int unsigned pos, logic [31:0] value);
        if (shadow_len >= Depth) return STS_FULL;
        if (pos > shadow_len) return STS_BADPOS;
        for (int unsigned i = shadow_len; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[pos] = value;
        shadow_len++;
        return STS_OK;
    endfunction

    // delete from the shadow list, shifting later cells down
    function automatic status_t shadow_delete(int unsigned pos);
        if (shadow_len == 0) return STS_EMPTY;
        if (pos >= shadow_len) return STS_BADPOS;
        for (int unsigned i = pos; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i + 1];
        shadow_len--;
        return STS_OK;
    endfunction

    // apply one action to the shadow list and predict its result beats
    function automatic void apply_list_action(action_t act, logic [31:0] value, logic [4:0] pos);
        status_t sts;
        sts = STS_OK;
        case (act)
            ACT_INS_HEAD: sts = shadow_insert(0, value);
            ACT_INS_TAIL: sts = shadow_insert(shadow_len, value);
            ACT_INS_POS:  sts = shadow_insert(pos, value);
            ACT_DEL_HEAD: sts = shadow_delete(0);
            ACT_DEL_TAIL: sts = (shadow_len == 0) ? STS_EMPTY : shadow_delete(shadow_len - 1);
            ACT_DEL_POS:  sts = shadow_delete(pos);
            ACT_COUNT:    sts = STS_OK;
            default: begin
                // read-all: one beat per entry, or a single empty beat
                if (shadow_len == 0) begin
                    push_result(STS_EMPTY, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < shadow_len; i++)
                        push_result(STS_OK, shadow_cells[i], (i + 1 == shadow_len));
                end
                return;
            end
        endcase
        push_result(sts, '0, 1'b1);
    endfunction

    // value mix with the signed extremes showing up often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // queue an input beat with its leading idle cycles
    task automatic push_cmd(action_t act, logic [31:0] value, logic [4:0] pos);
        list_cmd_t c;
        c.act   = act;
        c.value = value;
        c.pos   = pos;
        if (tx_calm != 0) begin
            tx_calm--;
            c.gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            tx_calm = $urandom_range(8, 30);
            c.gap   = 0;
        end else begin
            c.gap = $urandom_range(0, 7);
        end
        cmd_queue.push_back(c);
    endtask

    // driver: present queued beats after their idle cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (tx_wait < cmd_queue[0].gap) begin
                s_tvalid <= 1'b0;
                tx_wait  <= tx_wait + 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, cmd_queue[0].pos, cmd_queue[0].value};
                s_tuser  <= cmd_queue[0].act;
                tx_wait  <= 0;
                void'(cmd_queue.pop_front());
            end
        end
    end

    // monitor: check result beats, throttle ready, predict from taken input beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing pending: status %0d length %0d",
                           m_tuser, m_tdata[4:0]);
                    fail_count++;
                end else begin
                    list_result_t want;
                    want = result_queue.pop_front();
                    if (m_tuser !== want.sts) begin
                        $error("status mismatch: expected %0d, actual %0d", want.sts, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[4:0] !== want.len) begin
                        $error("list_length mismatch: expected %0d, actual %0d",
                               want.len, m_tdata[4:0]);
                        fail_count++;
                    end
                    if (m_tdata[36:5] !== want.entry) begin
                        $error("entry_value mismatch: expected %0d, actual %0d",
                               $signed(want.entry), $signed(m_tdata[36:5]));
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
                // stall before the next beat
                if (rx_calm != 0) begin
                    rx_calm  <= rx_calm - 1;
                    m_tready <= 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_calm  <= $urandom_range(8, 40);
                    m_tready <= 1'b1;
                end else begin
                    rx_draw  = $urandom_range(0, 7);
                    m_tready <= (rx_draw == 0);
                    rx_hold  <= rx_draw;
                end
            end else if (!m_tready) begin
                if (rx_hold > 1) rx_hold <= rx_hold - 1;
                else m_tready <= 1'b1;
            end
            if (s_tvalid && s_tready)
                apply_list_action(action_t'(s_tuser), s_tdata[31:0], s_tdata[36:32]);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned r;
        int unsigned mode;
        action_t     act;

        // empty list cases, emptiness wins over a bad position
        push_cmd(ACT_READ_ALL, pick_value(), 5'd0);
        push_cmd(ACT_DEL_HEAD, pick_value(), 5'd0);
        push_cmd(ACT_DEL_TAIL, pick_value(), 5'd0);
        push_cmd(ACT_DEL_POS, pick_value(), 5'd31);
        push_cmd(ACT_COUNT, pick_value(), 5'd0);
        // insert past the end, then at position equal to count
        push_cmd(ACT_INS_POS, 32'h1234_5678, 5'd1);
        push_cmd(ACT_INS_POS, 32'h8000_0000, 5'd0);
        push_cmd(ACT_INS_HEAD, 32'h7FFF_FFFF, 5'd0);
        push_cmd(ACT_INS_TAIL, 32'h0000_0000, 5'd0);
        push_cmd(ACT_INS_TAIL, 32'hFFFF_FFFF, 5'd0);
        push_cmd(ACT_INS_POS, 32'h5555_AAAA, 5'd2);
        push_cmd(ACT_INS_POS, 32'hAAAA_5555, 5'd5);
        push_cmd(ACT_READ_ALL, pick_value(), 5'd0);
        // delete at count, at the head by position, in the middle, tail and head
        push_cmd(ACT_DEL_POS, pick_value(), 5'd6);
        push_cmd(ACT_DEL_POS, pick_value(), 5'd0);
        push_cmd(ACT_DEL_POS, pick_value(), 5'd2);
        push_cmd(ACT_DEL_TAIL, pick_value(), 5'd0);
        push_cmd(ACT_DEL_HEAD, pick_value(), 5'd0);
        // fill up, then the full list cases
        for (int i = 0; i < 14; i++) push_cmd(ACT_INS_TAIL, pick_value(), 5'($urandom_range(0, 31)));
        push_cmd(ACT_INS_HEAD, pick_value(), 5'd0);
        push_cmd(ACT_INS_POS, pick_value(), 5'd16);
        push_cmd(ACT_INS_TAIL, pick_value(), 5'd0);
        push_cmd(ACT_READ_ALL, pick_value(), 5'd0);
        push_cmd(ACT_DEL_POS, pick_value(), 5'd15);
        push_cmd(ACT_COUNT, pick_value(), 5'd0);

        // random phases that grow, shrink or mix the list
        for (int phase = 0; phase < 8; phase++) begin
            mode = phase % 3;
            for (int k = 0; k < 30; k++) begin
                r = $urandom_range(0, 99);
                if (mode == 2) act = action_t'($urandom_range(ACT_INS_HEAD, ACT_READ_ALL));
                else if (r < 70) act = action_t'((mode == 0)
                                                 ? $urandom_range(ACT_INS_HEAD, ACT_INS_POS)
                                                 : $urandom_range(ACT_DEL_HEAD, ACT_DEL_POS));
                else if (r < 85) act = action_t'((mode == 0)
                                                 ? $urandom_range(ACT_DEL_HEAD, ACT_DEL_POS)
                                                 : $urandom_range(ACT_INS_HEAD, ACT_INS_POS));
                else if (r < 92) act = ACT_COUNT;
                else act = ACT_READ_ALL;
                push_cmd(act, pick_value(),
                         5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, 17)));
            end
        end

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every beat to be taken and answered
        while (cmd_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (result_queue.size() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        if (result_queue.size() != 0) begin
            $error("%0d result beats never arrived", result_queue.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
tb/sv/positional_list_engine_test.sv
